FILE: rtl/alic_pkg.sv
// shared constants for the ascii line integer calculator
package alic_pkg;

  // default arithmetic word width
  localparam int unsigned WordBitsDef = 16;

  // result port widths
  localparam int unsigned ResultBits = 16;
  localparam int unsigned StatusBits = 2;

  // characters
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_STAR  = 8'd42;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_SLASH = 8'd47;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  // status codes
  localparam logic [StatusBits-1:0] ST_OK    = 2'd0;
  localparam logic [StatusBits-1:0] ST_NOSEP = 2'd1;
  localparam logic [StatusBits-1:0] ST_DIVZ  = 2'd2;
  localparam logic [StatusBits-1:0] ST_BADOP = 2'd3;

endpackage

FILE: rtl/ascii_line_integer_calculator.sv
// Line calculator: bytes of "A op B" followed by a newline give one result beat with
// a status. Every byte other than a newline leaves the block ready for the next one. A
// newline keeps the block busy (in_stall_o high) while one shared WORD_BITS+1 bit adder
// works through the sums: a line that lacks a separator skips them; else the signs are
// applied, then + and - add, a bad operator or zero divisor gives an error status, *
// runs shift-and-add (one bit a cycle) and / restoring division (one quotient bit a
// cycle). A finished result waits in an output register, so the next line can be typed
// in while it is unread; a newline that finishes while the previous result is
// still unread holds until that beat is taken.
module ascii_line_integer_calculator #(
  parameter int unsigned WORD_BITS = alic_pkg::WordBitsDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [7:0]                            in_byte_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [alic_pkg::ResultBits-1:0] result_value_o,
  output logic [alic_pkg::StatusBits-1:0]       status_o
);
  import alic_pkg::*;

  localparam int unsigned W       = WORD_BITS;
  localparam int unsigned CntBits = $clog2(W);

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_OPER,
    PH_SEEK,
    PH_SECOND
  } phase_e;

  typedef enum logic [1:0] {
    SCAN_SKIP,
    SCAN_DIGITS,
    SCAN_STOP
  } scan_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SGNA,
    S_SGNB,
    S_DISP,
    S_MUL,
    S_ABSA,
    S_ABSB,
    S_DIV,
    S_FIX,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [W-1:0] acc;
    scan_e        scan;
    logic         neg;
  } num_t;

  localparam num_t NumClear = '{acc: '0, scan: SCAN_SKIP, neg: 1'b0};

  // atol-style scanner, one character
  function automatic num_t feed_num(num_t cur, logic [7:0] c);
    num_t         nxt;
    logic         dig;
    logic         ws;
    logic [W-1:0] d;
    nxt = cur;
    dig = (c >= CH_ZERO) && (c <= CH_NINE);
    ws  = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    d   = W'(c[3:0]);
    case (cur.scan)
      SCAN_SKIP: begin
        if (!ws) begin
          if (c == CH_PLUS) begin
            nxt.scan = SCAN_DIGITS;
          end else if (c == CH_MINUS) begin
            nxt.neg  = 1'b1;
            nxt.scan = SCAN_DIGITS;
          end else if (dig) begin
            nxt.acc  = d;
            nxt.scan = SCAN_DIGITS;
          end else begin
            nxt.scan = SCAN_STOP;
          end
        end
      end
      SCAN_DIGITS: begin
        if (dig) begin
          nxt.acc = (cur.acc << 3) + (cur.acc << 1) + d;
        end else begin
          nxt.scan = SCAN_STOP;
        end
      end
      default: begin
      end
    endcase
    return nxt;
  endfunction

  state_e                state_q, state_d;
  phase_e                phase_q, phase_d;
  num_t                  n1_q, n1_d, n2_q, n2_d;
  logic [7:0]            opc_q, opc_d;
  logic [W-1:0]          opa_q, opa_d, opb_q, opb_d, acc_q, acc_d;
  logic                  sa_q, sa_d, sb_q, sb_d, qneg_q, qneg_d;
  logic [CntBits-1:0]    cnt_q, cnt_d;
  logic [StatusBits-1:0] st_q, st_d;
  logic                  out_valid_q, out_valid_d;
  logic [ResultBits-1:0] out_res_q, out_res_d;
  logic [StatusBits-1:0] out_st_q, out_st_d;

  // shared adder / subtractor
  logic [W:0]   ux, uy;
  logic         usub;
  logic [W+1:0] usum;

  logic in_acc;
  logic last;

  assign in_acc = in_valid_i && (state_q == S_IDLE);
  assign last   = (cnt_q == CntBits'(W - 1));
  assign usum   = {1'b0, ux} + {1'b0, (usub ? ~uy : uy)} + (W + 2)'(usub);

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    n1_d        = n1_q;
    n2_d        = n2_q;
    opc_d       = opc_q;
    opa_d       = opa_q;
    opb_d       = opb_q;
    acc_d       = acc_q;
    sa_d        = sa_q;
    sb_d        = sb_q;
    qneg_d      = qneg_q;
    cnt_d       = cnt_q;
    st_d        = st_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_res_d   = out_res_q;
    out_st_d    = out_st_q;
    ux          = '0;
    uy          = '0;
    usub        = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_byte_i == CH_NL) begin
            opa_d   = n1_q.acc;
            opb_d   = n2_q.acc;
            sa_d    = n1_q.neg;
            sb_d    = n2_q.neg;
            n1_d    = NumClear;
            n2_d    = NumClear;
            phase_d = PH_FIRST;
            if (phase_q != PH_SECOND) begin
              st_d    = ST_NOSEP;
              acc_d   = '0;
              state_d = S_DONE;
            end else begin
              st_d    = ST_OK;
              state_d = S_SGNA;
            end
          end else begin
            case (phase_q)
              PH_FIRST: begin
                if (in_byte_i == CH_SPACE) begin
                  phase_d = PH_OPER;
                end else begin
                  n1_d = feed_num(n1_q, in_byte_i);
                end
              end
              PH_OPER: begin
                opc_d   = in_byte_i;
                // a space here doubles as the second separator
                phase_d = (in_byte_i == CH_SPACE) ? PH_SECOND : PH_SEEK;
              end
              PH_SEEK: begin
                if (in_byte_i == CH_SPACE) begin
                  phase_d = PH_SECOND;
                end
              end
              default: begin
                n2_d = feed_num(n2_q, in_byte_i);
              end
            endcase
          end
        end
      end
      S_SGNA: begin
        uy      = {1'b0, opa_q};
        usub    = sa_q;
        opa_d   = usum[W-1:0];
        state_d = S_SGNB;
      end
      S_SGNB: begin
        uy      = {1'b0, opb_q};
        usub    = sb_q;
        opb_d   = usum[W-1:0];
        state_d = S_DISP;
      end
      S_DISP: begin
        ux = {1'b0, opa_q};
        uy = {1'b0, opb_q};
        case (opc_q)
          CH_PLUS: begin
            acc_d   = usum[W-1:0];
            state_d = S_DONE;
          end
          CH_MINUS: begin
            usub    = 1'b1;
            acc_d   = usum[W-1:0];
            state_d = S_DONE;
          end
          CH_STAR: begin
            acc_d   = '0;
            cnt_d   = '0;
            state_d = S_MUL;
          end
          CH_SLASH: begin
            if (opb_q == '0) begin
              st_d    = ST_DIVZ;
              acc_d   = '0;
              state_d = S_DONE;
            end else begin
              qneg_d  = opa_q[W-1] ^ opb_q[W-1];
              state_d = S_ABSA;
            end
          end
          default: begin
            st_d    = ST_BADOP;
            acc_d   = '0;
            state_d = S_DONE;
          end
        endcase
      end
      S_MUL: begin
        ux      = {1'b0, acc_q};
        uy      = opb_q[0] ? {1'b0, opa_q} : '0;
        acc_d   = usum[W-1:0];
        opa_d   = opa_q << 1;
        opb_d   = opb_q >> 1;
        cnt_d   = cnt_q + CntBits'(1);
        if (last) begin
          state_d = S_DONE;
        end
      end
      S_ABSA: begin
        uy      = {1'b0, opa_q};
        usub    = opa_q[W-1];
        opa_d   = usum[W-1:0];
        state_d = S_ABSB;
      end
      S_ABSB: begin
        uy      = {1'b0, opb_q};
        usub    = opb_q[W-1];
        opb_d   = usum[W-1:0];
        acc_d   = '0;
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        // opa shifts the dividend out and the quotient in, acc holds the remainder
        ux    = {acc_q, opa_q[W-1]};
        uy    = {1'b0, opb_q};
        usub  = 1'b1;
        cnt_d = cnt_q + CntBits'(1);
        if (usum[W+1]) begin
          acc_d = usum[W-1:0];
          opa_d = {opa_q[W-2:0], 1'b1};
        end else begin
          acc_d = ux[W-1:0];
          opa_d = {opa_q[W-2:0], 1'b0};
        end
        if (last) begin
          state_d = S_FIX;
        end
      end
      S_FIX: begin
        uy      = {1'b0, opa_q};
        usub    = qneg_q;
        acc_d   = usum[W-1:0];
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_res_d   = ResultBits'(acc_q);
          out_st_d    = st_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_FIRST;
      n1_q        <= NumClear;
      n2_q        <= NumClear;
      opc_q       <= '0;
      opa_q       <= '0;
      opb_q       <= '0;
      acc_q       <= '0;
      sa_q        <= 1'b0;
      sb_q        <= 1'b0;
      qneg_q      <= 1'b0;
      cnt_q       <= '0;
      st_q        <= ST_OK;
      out_valid_q <= 1'b0;
      out_res_q   <= '0;
      out_st_q    <= ST_OK;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      n1_q        <= n1_d;
      n2_q        <= n2_d;
      opc_q       <= opc_d;
      opa_q       <= opa_d;
      opb_q       <= opb_d;
      acc_q       <= acc_d;
      sa_q        <= sa_d;
      sb_q        <= sb_d;
      qneg_q      <= qneg_d;
      cnt_q       <= cnt_d;
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
      out_res_q   <= out_res_d;
      out_st_q    <= out_st_d;
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_res_q;
  assign status_o       = out_st_q;

endmodule

FILE: rtl/alic_chk.sv
// port-level checks for the ascii line integer calculator, bound to the top level
module alic_chk (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_stall_o,
  input logic [7:0]                            in_byte_i,
  input logic                                  out_valid_o,
  input logic                                  out_stall_i,
  input logic signed [alic_pkg::ResultBits-1:0] result_value_o,
  input logic [alic_pkg::StatusBits-1:0]       status_o
);
  import alic_pkg::*;

  logic in_beat;

  assign in_beat = in_valid_i && !in_stall_o;

  // any error status carries a zero result
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_OK)) |-> (result_value_o == '0))
    else $error("error status with non-zero result");

  // a result beat held back keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(result_value_o) && $stable(status_o)))
    else $error("stalled result beat changed");

  // a newline makes the block busy for at least the next cycle
  a_nl_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && (in_byte_i == CH_NL)) |=> in_stall_o)
    else $error("newline did not start evaluation");

  // a new result never appears straight after a byte is taken
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !$rose(out_valid_o))
    else $error("result beat appeared without evaluation");

endmodule

bind ascii_line_integer_calculator alic_chk u_alic_chk (.*);
